// ===== hw/rtl/stb_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Slot table package
// Shared types and codes for the slot table with token budget.
// ---------------------------------------------------------------------------
package stb_pkg;

    localparam int SLOT_ID_W = 6;
    localparam int BUDGET_W  = 16;
    localparam int LIVE_W    = 7;

    localparam logic [LIVE_W-1:0] LIVE_MAX = 7'd127;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_ADVANCE = 2'd2
    } t_op;

    typedef struct packed {
        t_op                  cmd;
        logic [SLOT_ID_W-1:0] slot_id;
        logic [BUDGET_W-1:0]  token_budget;
    } t_in;

    typedef struct packed {
        logic                 status;
        logic [SLOT_ID_W-1:0] slot_index;
        logic [LIVE_W-1:0]    active_count;
    } t_out;

    typedef struct packed {
        logic load;
        logic idx_inc;
        logic alloc_step;
        logic adv_read;
        logic rel_do;
        logic finish;
    } t_ctl;

    typedef struct packed {
        logic cur_free;
        logic idx_last;
    } t_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/stb_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Slot table controller
// Sequences allocate scans, releases and advance sweeps over the datapath.
// ---------------------------------------------------------------------------
module stb_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire stb_pkg::t_op i_op,
    input  wire stb_pkg::t_sts i_sts,
    output stb_pkg::t_ctl     o_ctl,
    output logic              busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_REL,
        S_NOP,
        S_ADV,
        S_DRAIN
    } t_state;

    t_state        r_state;
    logic          r_busy;
    logic          w_accept;
    stb_pkg::t_ctl w_ctl;

    assign w_accept = start && !r_busy;

    always_comb begin
        w_ctl      = '0;
        w_ctl.load = w_accept;
        unique case (r_state)
            S_IDLE: begin
            end
            S_ALLOC: begin
                w_ctl.alloc_step = 1'b1;
                w_ctl.finish     = i_sts.cur_free || i_sts.idx_last;
                w_ctl.idx_inc    = !(i_sts.cur_free || i_sts.idx_last);
            end
            S_REL: begin
                w_ctl.rel_do = 1'b1;
                w_ctl.finish = 1'b1;
            end
            S_NOP: begin
                w_ctl.finish = 1'b1;
            end
            S_ADV: begin
                w_ctl.adv_read = 1'b1;
                w_ctl.idx_inc  = 1'b1;
            end
            S_DRAIN: begin
                w_ctl.finish = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_busy <= 1'b1;
                        unique case (i_op)
                            stb_pkg::OP_ALLOC:   r_state <= S_ALLOC;
                            stb_pkg::OP_RELEASE: r_state <= S_REL;
                            stb_pkg::OP_ADVANCE: r_state <= S_ADV;
                            default:             r_state <= S_NOP;
                        endcase
                    end
                end
                S_ADV: begin
                    if (i_sts.idx_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_ALLOC, S_REL, S_NOP, S_DRAIN: begin
                    if (w_ctl.finish) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_ctl = w_ctl;
    assign busy  = r_busy;

    a_busy_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy disagrees with controller state");

    a_sweep_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV && i_sts.idx_last) |=> (r_state == S_DRAIN))
        else $error("advance sweep did not drain after last slot");

    a_finish_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.finish |=> (r_state == S_IDLE && !r_busy))
        else $error("controller stayed busy after finishing a transaction");

endmodule
`default_nettype wire

// ===== hw/rtl/stb_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Slot table datapath
// Active marks, count and budget memory, slot counter, live count and result.
// ---------------------------------------------------------------------------
module stb_datapath #(
    parameter int SLOTS      = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire stb_pkg::t_in  i_item,
    input  wire stb_pkg::t_ctl i_ctl,
    output stb_pkg::t_sts      o_sts,
    output stb_pkg::t_out      o_result,
    output logic               o_valid
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BUD_W = stb_pkg::BUDGET_W;
    localparam int SID_W = stb_pkg::SLOT_ID_W;
    localparam int LIV_W = stb_pkg::LIVE_W;
    localparam int MEM_W = COUNT_BITS + BUD_W;
    localparam int CMP_W = (COUNT_BITS > BUD_W) ? COUNT_BITS : BUD_W;

    logic [MEM_W-1:0]      r_mem [SLOTS];
    logic [MEM_W-1:0]      r_rd;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_pidx;
    logic                  r_pvld;
    logic [SID_W-1:0]      r_sid;
    logic [BUD_W-1:0]      r_bud;
    logic [SLOTS-1:0]      r_active;
    logic [SLOTS-1:0]      n_active;
    logic [LIV_W-1:0]      r_live;
    logic [LIV_W-1:0]      n_live;
    stb_pkg::t_out         r_out;
    logic                  r_valid;

    logic                  w_cur_free;
    logic                  w_idx_last;
    logic                  w_take;
    logic [IDX_W-1:0]      w_rel_idx;
    logic                  w_rel_hit;
    logic                  w_proc;
    logic [COUNT_BITS-1:0] w_cnt_nxt;
    logic [BUD_W-1:0]      w_rd_bud;
    logic                  w_expire;
    logic                  w_dec;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [MEM_W-1:0]      w_wdata;

    assign w_cur_free = !r_active[r_idx];
    assign w_idx_last = (r_idx == IDX_W'(SLOTS - 1));
    assign w_take     = i_ctl.alloc_step && w_cur_free;
    assign w_rel_idx  = IDX_W'(r_sid);
    assign w_rel_hit  = i_ctl.rel_do && (32'(r_sid) < 32'(SLOTS)) && r_active[w_rel_idx];
    assign w_proc     = r_pvld && r_active[r_pidx];
    assign w_cnt_nxt  = r_rd[MEM_W-1 -: COUNT_BITS] + COUNT_BITS'(1);
    assign w_rd_bud   = r_rd[BUD_W-1:0];
    assign w_expire   = w_proc && (CMP_W'(w_cnt_nxt) >= CMP_W'(w_rd_bud));
    assign w_dec      = w_rel_hit || w_expire;

    always_comb begin
        n_live = r_live;
        if (w_take && (r_live != stb_pkg::LIVE_MAX)) begin
            n_live = r_live + LIV_W'(1);
        end else if (w_dec && (r_live != '0)) begin
            n_live = r_live - LIV_W'(1);
        end
    end

    always_comb begin
        n_active = r_active;
        if (w_take) begin
            n_active[r_idx] = 1'b1;
        end
        if (w_rel_hit) begin
            n_active[w_rel_idx] = 1'b0;
        end
        if (w_expire) begin
            n_active[r_pidx] = 1'b0;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = '0;
        if (w_take) begin
            w_we    = 1'b1;
            w_waddr = r_idx;
            w_wdata = {COUNT_BITS'(0), r_bud};
        end else if (w_proc) begin
            w_we    = 1'b1;
            w_waddr = r_pidx;
            w_wdata = w_expire ? '0 : {w_cnt_nxt, w_rd_bud};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx;
        if (i_ctl.load) begin
            r_sid <= i_item.slot_id;
            r_bud <= i_item.token_budget;
        end
        if (i_ctl.finish) begin
            r_out.status       <= (i_ctl.alloc_step && !w_cur_free) ?
                                  stb_pkg::ST_FULL : stb_pkg::ST_DONE;
            r_out.slot_index   <= w_take ? SID_W'(r_idx) : '0;
            r_out.active_count <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_pvld   <= 1'b0;
            r_active <= '0;
            r_live   <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_idx <= '0;
            end else if (i_ctl.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            r_pvld   <= i_ctl.adv_read;
            r_active <= n_active;
            r_live   <= n_live;
            r_valid  <= i_ctl.finish;
        end
    end

    assign o_sts.cur_free = w_cur_free;
    assign o_sts.idx_last = w_idx_last;
    assign o_result       = r_out;
    assign o_valid        = r_valid;

    a_live_matches_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SLOTS > 127) || (32'(r_live) == $countones(r_active)))
        else $error("live count disagrees with active marks");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for more than one cycle");

    a_take_marks_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_active[$past(r_idx)])
        else $error("allocated slot not marked active");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pvld |-> !i_ctl.alloc_step)
        else $error("advance update overlaps an allocate step");

endmodule
`default_nettype wire

// ===== hw/rtl/slot_table_with_token_budget_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Slot table with token budget
// First-free slot allocator whose slots expire after a per-slot step budget.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Release and the
// unused command finish in their own controller state. Allocate checks one
// slot per cycle from slot 0 and stops at the lowest free slot, or after the
// last slot with a full status when the table is full. Advance sweeps every
// slot through the single read port of the count and budget memory, one slot
// per cycle, and ends in a drain state that updates the last slot. The result
// is shown on o_result for exactly one cycle with o_valid and cannot be held
// off; busy is already low in that cycle, so the next transaction may start
// while the result is on the ports.
// ---------------------------------------------------------------------------
module slot_table_with_token_budget_top #(
    parameter int SLOTS      = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire stb_pkg::t_in i_item,
    output logic              busy,
    output stb_pkg::t_out     o_result,
    output logic              o_valid
);

    stb_pkg::t_ctl w_ctl;
    stb_pkg::t_sts w_sts;

    stb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_item.cmd),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .busy    (busy)
    );

    stb_datapath #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (w_ctl),
        .o_sts    (w_sts),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

endmodule
`default_nettype wire

// ===== tb/slot_table_with_token_budget_top_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Slot table with token budget testbench
// Drives allocate, release, advance and unused commands through the start and
// busy handshake, first from a short table and then in random bursts that fill, churn and
// drain the table. Every result is checked field by field against the given values of a fixed
// directed row, else against a cycle-free model of the slot table kept in the testbench.
// ---------------------------------------------------------------------------
module slot_table_with_token_budget_top_test;

    localparam int SLOTS        = 64;
    localparam int COUNT_BITS   = 16;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = SLOTS + 4;
    localparam stb_pkg::t_op OP_NONE = stb_pkg::t_op'(2'd3);

    typedef enum int {
        MIX_FILL,
        MIX_CHURN,
        MIX_DRAIN
    } t_mix;

    typedef struct {
        stb_pkg::t_in  item;
        bit            fixed;
        stb_pkg::t_out want;
    } t_stim_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    stb_pkg::t_in  i_item;
    logic          busy;
    stb_pkg::t_out o_result;
    logic          o_valid;

    bit                           slot_on [SLOTS];
    bit [COUNT_BITS-1:0]          slot_steps [SLOTS];
    bit [stb_pkg::BUDGET_W-1:0]   slot_budget [SLOTS];
    bit [stb_pkg::LIVE_W-1:0]     live_slots;

    stb_pkg::t_out pending_results[$];
    t_stim_row     directed_rows[$];
    int            error_count;
    int            cycle_count;
    bit            steady;

    slot_table_with_token_budget_top #(
        .SLOTS(SLOTS),
        .COUNT_BITS(COUNT_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_item(i_item),
        .busy(busy),
        .o_result(o_result),
        .o_valid(o_valid)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic stb_pkg::t_in make_cmd(stb_pkg::t_op op, int sid, int bud);
        stb_pkg::t_in item;
        item.cmd          = op;
        item.slot_id      = sid[stb_pkg::SLOT_ID_W-1:0];
        item.token_budget = bud[stb_pkg::BUDGET_W-1:0];
        return item;
    endfunction

    function automatic t_stim_row given_row(stb_pkg::t_op op, int sid, int bud,
                                            int idx, int cnt);
        t_stim_row r;
        r.item              = make_cmd(op, sid, bud);
        r.fixed             = 1'b1;
        r.want.status       = stb_pkg::ST_DONE;
        r.want.slot_index   = idx[stb_pkg::SLOT_ID_W-1:0];
        r.want.active_count = cnt[stb_pkg::LIVE_W-1:0];
        return r;
    endfunction

    function automatic t_stim_row open_row(stb_pkg::t_op op, int sid, int bud);
        t_stim_row r;
        r.item  = make_cmd(op, sid, bud);
        r.fixed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic void free_slot(int k);
        slot_on[k]     = 1'b0;
        slot_steps[k]  = '0;
        slot_budget[k] = '0;
        if (live_slots != 0) begin
            live_slots = live_slots - 1'b1;
        end
    endfunction

    function automatic stb_pkg::t_out apply_slot_cmd(stb_pkg::t_in item);
        stb_pkg::t_out res;
        res        = '0;
        res.status = stb_pkg::ST_DONE;
        case (item.cmd)
            stb_pkg::OP_ALLOC: begin
                res.status = stb_pkg::ST_FULL;
                for (int k = 0; k < SLOTS; k++) begin
                    if (!slot_on[k]) begin
                        slot_on[k]     = 1'b1;
                        slot_steps[k]  = '0;
                        slot_budget[k] = item.token_budget;
                        if (live_slots < stb_pkg::LIVE_MAX) begin
                            live_slots = live_slots + 1'b1;
                        end
                        res.status     = stb_pkg::ST_DONE;
                        res.slot_index = k[stb_pkg::SLOT_ID_W-1:0];
                        break;
                    end
                end
            end
            stb_pkg::OP_RELEASE: begin
                if (int'(item.slot_id) < SLOTS && slot_on[item.slot_id]) begin
                    free_slot(int'(item.slot_id));
                end
            end
            stb_pkg::OP_ADVANCE: begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (slot_on[k]) begin
                        slot_steps[k] = slot_steps[k] + 1'b1;
                        if (32'(slot_steps[k]) >= 32'(slot_budget[k])) begin
                            free_slot(k);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.active_count = live_slots;
        return res;
    endfunction

    function automatic int pick_release_slot();
        int live_ids[$];
        for (int k = 0; k < SLOTS; k++) begin
            if (slot_on[k]) begin
                live_ids.push_back(k);
            end
        end
        if (live_ids.size() == 0 || $urandom_range(9) < 3) begin
            return $urandom_range(SLOTS - 1);
        end
        return live_ids[$urandom_range(live_ids.size() - 1)];
    endfunction

    function automatic int pick_budget(bit long_lived);
        if (long_lived || $urandom_range(3) == 0) begin
            return $urandom_range(65535);
        end
        return $urandom_range(8);
    endfunction

    function automatic stb_pkg::t_in random_slot_cmd(t_mix mix);
        int r;
        int p_alloc;
        int p_release;
        int p_advance;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                p_alloc   = 88;
                p_release = 5;
                p_advance = 5;
            end
            MIX_CHURN: begin
                p_alloc   = 40;
                p_release = 22;
                p_advance = 33;
            end
            default: begin
                p_alloc   = 10;
                p_release = 58;
                p_advance = 28;
            end
        endcase
        if (r < p_alloc) begin
            return make_cmd(stb_pkg::OP_ALLOC, $urandom_range(63),
                            pick_budget(mix == MIX_FILL));
        end else if (r < p_alloc + p_release) begin
            return make_cmd(stb_pkg::OP_RELEASE, pick_release_slot(), $urandom_range(65535));
        end else if (r < p_alloc + p_release + p_advance) begin
            return make_cmd(stb_pkg::OP_ADVANCE, $urandom_range(63), $urandom_range(65535));
        end
        return make_cmd(OP_NONE, $urandom_range(63), $urandom_range(65535));
    endfunction

    task automatic send_cmd(input stb_pkg::t_in item, input bit fixed,
                            input stb_pkg::t_out want);
        int            gap;
        stb_pkg::t_out predicted;
        gap = 0;
        if (!steady && $urandom_range(99) < 22) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
        end
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= item;
        do begin
            @(posedge i_clk);
        end while (busy);
        predicted = apply_slot_cmd(item);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        stb_pkg::t_out want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no transaction pending, got %p", $time, o_result);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, o_result.status);
                    error_count++;
                end
                if (o_result.slot_index !== want.slot_index) begin
                    $display("%0t: slot_index expected %0d got %0d",
                             $time, want.slot_index, o_result.slot_index);
                    error_count++;
                end
                if (o_result.active_count !== want.active_count) begin
                    $display("%0t: active_count expected %0d got %0d",
                             $time, want.active_count, o_result.active_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int   sent;
        int   burst;
        int   burst_len;
        t_mix mix;

        start       = 1'b0;
        i_item      = '0;
        i_rst_n     = 1'b0;
        error_count = 0;
        cycle_count = 0;
        steady      = 1'b0;

        directed_rows.push_back(given_row(stb_pkg::OP_ADVANCE, 0, 0, 0, 0));
        directed_rows.push_back(given_row(stb_pkg::OP_RELEASE, 0, 0, 0, 0));
        directed_rows.push_back(given_row(OP_NONE, 63, 65535, 0, 0));
        directed_rows.push_back(given_row(stb_pkg::OP_ALLOC, 0, 0, 0, 1));
        directed_rows.push_back(given_row(stb_pkg::OP_ADVANCE, 0, 0, 0, 0));
        directed_rows.push_back(given_row(stb_pkg::OP_ALLOC, 63, 65535, 0, 1));
        directed_rows.push_back(given_row(stb_pkg::OP_ALLOC, 0, 2, 1, 2));
        directed_rows.push_back(given_row(stb_pkg::OP_ALLOC, 0, 1, 2, 3));
        directed_rows.push_back(given_row(stb_pkg::OP_RELEASE, 63, 0, 0, 3));
        directed_rows.push_back(given_row(stb_pkg::OP_RELEASE, 1, 0, 0, 2));
        directed_rows.push_back(open_row(stb_pkg::OP_ALLOC, 0, 3));
        directed_rows.push_back(open_row(stb_pkg::OP_ADVANCE, 0, 0));
        directed_rows.push_back(open_row(stb_pkg::OP_ALLOC, 0, 0));
        directed_rows.push_back(open_row(stb_pkg::OP_ADVANCE, 0, 0));
        directed_rows.push_back(open_row(stb_pkg::OP_ADVANCE, 63, 65535));
        directed_rows.push_back(open_row(stb_pkg::OP_ADVANCE, 0, 0));
        directed_rows.push_back(open_row(stb_pkg::OP_RELEASE, 0, 65535));
        directed_rows.push_back(open_row(stb_pkg::OP_RELEASE, 0, 0));
        directed_rows.push_back(open_row(stb_pkg::OP_ALLOC, 42, 32768));
        directed_rows.push_back(open_row(stb_pkg::OP_ALLOC, 21, 1));
        directed_rows.push_back(open_row(stb_pkg::OP_ADVANCE, 63, 65535));
        directed_rows.push_back(open_row(OP_NONE, 0, 0));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            send_cmd(directed_rows[n].item, directed_rows[n].fixed, directed_rows[n].want);
        end
        wait_for_results();

        sent  = 0;
        burst = 0;
        while (sent < RANDOM_ITEMS) begin
            mix       = (burst < 2) ? MIX_FILL : t_mix'($urandom_range(2));
            burst_len = (mix == MIX_FILL) ? $urandom_range(60, 80) : $urandom_range(15, 40);
            for (int n = 0; n < burst_len && sent < RANDOM_ITEMS; n++) begin
                steady = (sent >= 150 && sent < 250);
                send_cmd(random_slot_cmd(mix), 1'b0, '0);
                sent++;
            end
            if (burst == 0 || $urandom_range(2) == 0) begin
                wait_for_results();
            end
            burst++;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
